@@ rtl/mbe_pkg.sv @@
`default_nettype none

package mbe_pkg;

   localparam int FRACTION_BITS_DEFAULT = 56;
   localparam int INDEX_BITS_DEFAULT = 28;

   localparam int COORD_BITS = 64;
   localparam int WIDE_BITS = 2 * COORD_BITS;
   localparam int WIDTH_BITS = 15;
   localparam int ITER_BITS = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = WIDTH_BITS'(1);
   localparam logic [ITER_BITS-1:0] MAX_ITERATIONS_RESET = ITER_BITS'(100000);

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REAL_LEFT      = 3'd0,
      CSR_REAL_STEP      = 3'd1,
      CSR_IMAG_LOWER     = 3'd2,
      CSR_IMAG_STEP      = 3'd3,
      CSR_IMAGE_WIDTH    = 3'd4,
      CSR_MAX_ITERATIONS = 3'd5
   } csr_reg_type;

   // Clamps a 128-bit two's complement value into the signed 64-bit range.
   function automatic logic signed [COORD_BITS-1:0] sat64(input logic signed [WIDE_BITS-1:0] v);
      logic [COORD_BITS:0] top;
      top = v[WIDE_BITS-1:COORD_BITS-1];
      if (top == '0 || top == '1) begin
         return v[COORD_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

   function automatic logic signed [COORD_BITS-1:0] add_sat64(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS-1:0] s;
      s = a + b;
      if (a[COORD_BITS-1] == b[COORD_BITS-1] && s[COORD_BITS-1] != a[COORD_BITS-1]) begin
         return a[COORD_BITS-1] ? COORD_MIN : COORD_MAX;
      end else begin
         return s;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/mandelbrot_escape_count.sv @@
`default_nettype none

// Mandelbrot escape-time counter. Each item is a linear pixel index; the block splits it into
// row and column by the configured image width, maps them to a point c in signed fixed point
// (FRACTION_BITS fraction bits, 64 bits total) and iterates z = z*z + c from zero until |z|^2
// reaches 4 or max_iterations iterations have run, then returns the index with the count.
// One item is handled at a time and req_stall is high while it is worked on. An item first
// goes through setup (a one-bit-per-cycle divider, then two 64x64 products for the point
// mapping), then the iterations, and DONE hands its result to the output register. All
// products go through one 32x32 multiplier, four partial products per 64x64 product and three
// products per iteration, which sets the iteration time. A finished result waits in the output
// register, so the next item is taken while the previous result is still stalled.

module mandelbrot_escape_count
   import mbe_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [INDEX_BITS-1:0]     req_pixel_index,

   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [INDEX_BITS-1:0]     rsp_result_index,
   output      logic [ITER_BITS-1:0]      rsp_iteration_count,

   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int DivCntBits = $clog2(INDEX_BITS);
   localparam logic [DivCntBits-1:0] DivLast = DivCntBits'(INDEX_BITS - 1);
   localparam logic signed [COORD_BITS-1:0] Four = 64'sd4 << FRACTION_BITS;

   typedef enum logic [3:0] {
      IDLE, DIV, MAPC, CX, CY, CHECK, MUL, MFIN, YUPD, XUPD, SQX, SXX, SYY, DONE
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   // Configuration registers.
   logic signed [COORD_BITS-1:0] real_left_ff, real_left_in, real_step_ff, real_step_in;
   logic signed [COORD_BITS-1:0] imag_lower_ff, imag_lower_in, imag_step_ff, imag_step_in;
   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [ITER_BITS-1:0] max_ff, max_in;

   // Divider.
   logic [INDEX_BITS-1:0] idx_ff, idx_in, q_ff, q_in;
   logic [WIDTH_BITS-1:0] rem_ff, rem_in, w_eff;
   logic [DivCntBits-1:0] dcnt_ff, dcnt_in;
   logic [WIDTH_BITS:0] trial, trial_diff;
   logic trial_ge;

   // Shared multiplier.
   logic [COORD_BITS-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic neg_ff, neg_in;
   logic [2:0] mcnt_ff, mcnt_in;
   logic [COORD_BITS-1:0] pp_ff, pp_in;
   logic [1:0] psh_ff, psh_in;
   logic [31:0] part_a, part_b;
   logic [WIDE_BITS-1:0] pp_shifted;
   logic signed [WIDE_BITS-1:0] acc_ff, acc_in;
   logic mul_go;
   logic signed [COORD_BITS-1:0] mul_a, mul_b;

   // Iteration state.
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in, x_ff, x_in, y_ff, y_in;
   logic signed [COORD_BITS-1:0] len_ff, len_in;
   logic signed [WIDE_BITS-1:0] xx_ff, xx_in, yy_ff, yy_in;
   logic [ITER_BITS-1:0] count_ff, count_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [ITER_BITS-1:0] rsp_count_ff, rsp_count_in;

   assign w_eff = (width_ff == '0) ? WIDTH_BITS'(1) : width_ff;
   assign trial = {rem_ff, q_ff[INDEX_BITS-1]};
   assign trial_diff = trial - {1'b0, w_eff};
   assign trial_ge = (trial >= {1'b0, w_eff});

   assign part_a = mcnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign part_b = mcnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (psh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      real_left_in = real_left_ff;
      real_step_in = real_step_ff;
      imag_lower_in = imag_lower_ff;
      imag_step_in = imag_step_ff;
      width_in = width_ff;
      max_in = max_ff;
      idx_in = idx_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      neg_in = neg_ff;
      mcnt_in = mcnt_ff;
      pp_in = pp_ff;
      psh_in = psh_ff;
      acc_in = acc_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      x_in = x_ff;
      y_in = y_ff;
      xx_in = xx_ff;
      yy_in = yy_ff;
      len_in = len_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      mul_go = 1'b0;
      mul_a = x_ff;
      mul_b = y_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_REAL_LEFT:      real_left_in = csr_write_data;
            CSR_REAL_STEP:      real_step_in = csr_write_data;
            CSR_IMAG_LOWER:     imag_lower_in = csr_write_data;
            CSR_IMAG_STEP:      imag_step_in = csr_write_data;
            CSR_IMAGE_WIDTH:    width_in = csr_write_data[WIDTH_BITS-1:0];
            CSR_MAX_ITERATIONS: max_in = csr_write_data[ITER_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               idx_in = req_pixel_index;
               q_in = req_pixel_index;
               rem_in = '0;
               dcnt_in = '0;
               state_in = DIV;
            end
         end
         DIV: begin
            q_in = {q_ff[INDEX_BITS-2:0], trial_ge};
            rem_in = trial_ge ? trial_diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
            dcnt_in = dcnt_ff + DivCntBits'(1);
            if (dcnt_ff == DivLast) begin
               state_in = MAPC;
            end
         end
         MAPC: begin
            mul_go = 1'b1;
            mul_a = {{(COORD_BITS-WIDTH_BITS){1'b0}}, rem_ff};
            mul_b = real_step_ff;
            ret_in = CX;
         end
         CX: begin
            cx_in = sat64(acc_ff + {{COORD_BITS{real_left_ff[COORD_BITS-1]}}, real_left_ff});
            mul_go = 1'b1;
            mul_a = {{(COORD_BITS-INDEX_BITS){1'b0}}, q_ff};
            mul_b = imag_step_ff;
            ret_in = CY;
         end
         CY: begin
            cy_in = sat64(acc_ff + {{COORD_BITS{imag_lower_ff[COORD_BITS-1]}}, imag_lower_ff});
            x_in = '0;
            y_in = '0;
            xx_in = '0;
            yy_in = '0;
            len_in = '0;
            count_in = '0;
            state_in = CHECK;
         end
         CHECK: begin
            if (count_ff >= max_ff || len_ff >= Four) begin
               state_in = DONE;
            end else begin
               mul_go = 1'b1;
               mul_a = x_ff;
               mul_b = y_ff;
               ret_in = YUPD;
            end
         end
         MUL: begin
            if (mcnt_ff != 3'd4) begin
               pp_in = 64'(part_a) * 64'(part_b);
               psh_in = {1'b0, mcnt_ff[0]} + {1'b0, mcnt_ff[1]};
            end else begin
               state_in = MFIN;
            end
            if (mcnt_ff != 3'd0) begin
               acc_in = acc_ff + pp_shifted;
            end
            mcnt_in = mcnt_ff + 3'd1;
         end
         MFIN: begin
            acc_in = neg_ff ? (~acc_ff + WIDE_BITS'(1)) : acc_ff;
            state_in = ret_ff;
         end
         YUPD: begin
            // The doubling of x*y is folded into a shift one place shorter.
            y_in = add_sat64(sat64(acc_ff >>> (FRACTION_BITS - 1)), cy_ff);
            acc_in = xx_ff - yy_ff;
            state_in = XUPD;
         end
         XUPD: begin
            x_in = add_sat64(sat64(acc_ff >>> FRACTION_BITS), cx_ff);
            state_in = SQX;
         end
         SQX: begin
            mul_go = 1'b1;
            mul_a = x_ff;
            mul_b = x_ff;
            ret_in = SXX;
         end
         SXX: begin
            xx_in = acc_ff;
            mul_go = 1'b1;
            mul_a = y_ff;
            mul_b = y_ff;
            ret_in = SYY;
         end
         SYY: begin
            // The full squares are kept, since the next iteration needs them again.
            yy_in = acc_ff;
            len_in = add_sat64(sat64(xx_ff >>> FRACTION_BITS), sat64(acc_ff >>> FRACTION_BITS));
            count_in = count_ff + ITER_BITS'(1);
            state_in = CHECK;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_count_in = count_ff;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      // The multiplier works on magnitudes; the sign is applied once the sum is complete.
      if (mul_go) begin
         ma_in = mul_a[COORD_BITS-1] ? (~mul_a + COORD_BITS'(1)) : mul_a;
         mb_in = mul_b[COORD_BITS-1] ? (~mul_b + COORD_BITS'(1)) : mul_b;
         neg_in = mul_a[COORD_BITS-1] ^ mul_b[COORD_BITS-1];
         mcnt_in = '0;
         acc_in = '0;
         state_in = MUL;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
      dcnt_ff <= dcnt_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      mcnt_ff <= mcnt_in;
      pp_ff <= pp_in;
      psh_ff <= psh_in;
      acc_ff <= acc_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      x_ff <= x_in;
      y_ff <= y_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      len_ff <= len_in;
      count_ff <= count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff <= IDLE;
         ret_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         real_left_ff <= '0;
         real_step_ff <= '0;
         imag_lower_ff <= '0;
         imag_step_ff <= '0;
         width_ff <= IMAGE_WIDTH_RESET;
         max_ff <= MAX_ITERATIONS_RESET;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         real_left_ff <= real_left_in;
         real_step_ff <= real_step_in;
         imag_lower_ff <= imag_lower_in;
         imag_step_ff <= imag_step_in;
         width_ff <= width_in;
         max_ff <= max_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_iteration_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == CHECK |-> count_ff <= max_ff)
      else $error("iteration count passed the limit");

   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == CX |-> rem_ff < w_eff)
      else $error("column not below the image width after division");

   a_square_sign: assert property (@(posedge clock) disable iff (reset)
      state_ff == SXX |-> !acc_ff[WIDE_BITS-1])
      else $error("square of x came out negative");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
      else $error("result raised outside the completion state");
`endif

endmodule

`default_nettype wire
